/* rtl/core/svpwm_pkg.sv */
package svpwm_pkg;

    localparam int unsigned InW   = 13;
    localparam int unsigned OutW  = 15;
    localparam int unsigned PerW  = 12;
    localparam int unsigned QW    = 16;   // quotient bits of the rescale divider
    localparam int unsigned RemW  = 30;   // partial remainder width
    localparam logic [PerW-1:0] PeriodReset = 12'd1000;

    typedef enum logic [2:0] {
        SEC_ZERO = 3'd0, SEC_ONE = 3'd1, SEC_TWO = 3'd2, SEC_THREE = 3'd3,
        SEC_FOUR = 3'd4, SEC_FIVE = 3'd5, SEC_SIX = 3'd6, SEC_SEVEN = 3'd7
    } t_sector;

    // Data carried by each cell of the divider chain.
    typedef struct packed {
        t_sector             code;
        logic [PerW-1:0]     per;
        logic signed [17:0]  t1;
        logic signed [17:0]  t2;
        logic                ovm;
        logic                neg1;
        logic                neg2;
        logic [RemW-1:0]     num1;
        logic [RemW-1:0]     num2;
        logic [RemW-1:0]     rem1;
        logic [RemW-1:0]     rem2;
        logic [17:0]         den;
        logic [QW-1:0]       q1;
        logic [QW-1:0]       q2;
    } t_div_bus;

endpackage

/* rtl/core/svpwm_front.sv */
module svpwm_front (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [svpwm_pkg::InW-1:0]    i_alpha,
    input  logic signed [svpwm_pkg::InW-1:0]    i_beta,
    input  logic [svpwm_pkg::PerW-1:0]          i_per,
    output svpwm_pkg::t_div_bus                 o_bus
);
    // Products are registered before the truncating divides and sector test.
    logic signed [22:0] r_ka, r_kb;
    logic signed [14:0] r_a3;
    logic signed [12:0] r_be;
    logic [svpwm_pkg::PerW-1:0] r_per;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ka  <= 23'(i_alpha) * 23'sd173;
            r_kb  <= 23'(i_beta) * 23'sd173;
            r_a3  <= 15'(i_alpha) * 15'sd3;
            r_be  <= i_beta;
            r_per <= i_per;
        end
    end

    // Exact floor of n / 25 for n below 2^18 by a reciprocal multiply.
    function automatic logic [17:0] div25(input logic [17:0] n);
        logic [36:0] prod;
        prod = 37'(n) * 37'd335545;
        return {4'd0, prod[36:23]};
    endfunction

    // Divide the products by 200 and 100 on magnitudes, truncating toward zero.
    logic [22:0] ka_mag, kb_mag;
    logic [17:0] ka_q, kb1_q, kb2_q;
    logic signed [18:0] n_ka200, n_kb100, n_kb200;
    logic signed [14:0] n_a32;

    always_comb begin
        ka_mag  = r_ka[22] ? 23'(-r_ka) : 23'(r_ka);
        kb_mag  = r_kb[22] ? 23'(-r_kb) : 23'(r_kb);
        ka_q    = div25(ka_mag[20:3]);
        kb1_q   = div25(kb_mag[19:2]);
        kb2_q   = div25(kb_mag[20:3]);
        n_ka200 = r_ka[22] ? -$signed({1'b0, ka_q}) : $signed({1'b0, ka_q});
        n_kb100 = r_kb[22] ? -$signed({1'b0, kb1_q}) : $signed({1'b0, kb1_q});
        n_kb200 = r_kb[22] ? -$signed({1'b0, kb2_q}) : $signed({1'b0, kb2_q});
        n_a32   = r_a3 / 15'sd2;
    end

    // Quotients are registered before the sector test.
    logic signed [18:0] r_ka200, r_kb100, r_kb200;
    logic signed [14:0] r_a32;
    logic signed [12:0] r_be2;
    logic [svpwm_pkg::PerW-1:0] r_per2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ka200 <= n_ka200;
            r_kb100 <= n_kb100;
            r_kb200 <= n_kb200;
            r_a32   <= n_a32;
            r_be2   <= r_be;
            r_per2  <= r_per;
        end
    end

    logic signed [22:0] ka200, kam200, kb100, kb200, a32, am32, bh;
    logic signed [22:0] u2, u3, x, y, z, t1, t2, sum;
    logic [2:0] code;
    logic signed [23:0] per_s;

    always_comb begin
        ka200  = 23'(r_ka200);
        kam200 = -ka200;
        kb100  = 23'(r_kb100);
        kb200  = 23'(r_kb200);
        a32    = 23'(r_a32);
        am32   = -a32;
        bh     = 23'(r_be2) / 23'sd2;
        u2 = ka200 - bh;
        u3 = kam200 - bh;
        code = {u3 > 0, u2 > 0, r_be2 > 13'sd0};
        x = kb100;
        y = a32 + kb200;
        z = am32 + kb200;
        case (svpwm_pkg::t_sector'(code))
            svpwm_pkg::SEC_ONE:   begin t1 = z;  t2 = y;  end
            svpwm_pkg::SEC_TWO:   begin t1 = y;  t2 = -x; end
            svpwm_pkg::SEC_THREE: begin t1 = -z; t2 = x;  end
            svpwm_pkg::SEC_FOUR:  begin t1 = -x; t2 = z;  end
            svpwm_pkg::SEC_FIVE:  begin t1 = x;  t2 = -y; end
            default:              begin t1 = -y; t2 = -z; end
        endcase
        sum = t1 + t2;
        per_s = {12'd0, r_per2};
        o_bus = '0;
        o_bus.code = svpwm_pkg::t_sector'(code);
        o_bus.per  = r_per2;
        o_bus.t1   = 18'(t1);
        o_bus.t2   = 18'(t2);
        o_bus.ovm  = 24'(sum) > per_s;
        o_bus.den  = 18'(sum);
    end
endmodule

/* rtl/core/svpwm_prod.sv */
module svpwm_prod (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  svpwm_pkg::t_div_bus  i_bus,
    output svpwm_pkg::t_div_bus  o_bus
);
    // Numerators |T*P| for the chain; register after the multiply.
    logic [17:0] m1, m2;
    svpwm_pkg::t_div_bus n_bus, r_bus;

    always_comb begin
        m1 = i_bus.t1[17] ? 18'(-i_bus.t1) : 18'(i_bus.t1);
        m2 = i_bus.t2[17] ? 18'(-i_bus.t2) : 18'(i_bus.t2);
        n_bus      = i_bus;
        n_bus.neg1 = i_bus.t1[17];
        n_bus.neg2 = i_bus.t2[17];
        n_bus.num1 = svpwm_pkg::RemW'(m1) * svpwm_pkg::RemW'(i_bus.per);
        n_bus.num2 = svpwm_pkg::RemW'(m2) * svpwm_pkg::RemW'(i_bus.per);
        n_bus.rem1 = '0;
        n_bus.rem2 = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;
endmodule

/* rtl/core/svpwm_div_cell.sv */
module svpwm_div_cell (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  svpwm_pkg::t_div_bus  i_bus,
    output svpwm_pkg::t_div_bus  o_bus
);
    // One restoring step for both quotients: shift in the top numerator bit.
    logic [svpwm_pkg::RemW-1:0] s1, s2, d;
    logic g1, g2;
    svpwm_pkg::t_div_bus n_bus, r_bus;

    always_comb begin
        d  = svpwm_pkg::RemW'(i_bus.den);
        s1 = {i_bus.rem1[svpwm_pkg::RemW-2:0], i_bus.num1[svpwm_pkg::RemW-1]};
        s2 = {i_bus.rem2[svpwm_pkg::RemW-2:0], i_bus.num2[svpwm_pkg::RemW-1]};
        g1 = s1 >= d;
        g2 = s2 >= d;
        n_bus      = i_bus;
        n_bus.num1 = {i_bus.num1[svpwm_pkg::RemW-2:0], 1'b0};
        n_bus.num2 = {i_bus.num2[svpwm_pkg::RemW-2:0], 1'b0};
        n_bus.rem1 = g1 ? s1 - d : s1;
        n_bus.rem2 = g2 ? s2 - d : s2;
        n_bus.q1   = {i_bus.q1[svpwm_pkg::QW-2:0], g1};
        n_bus.q2   = {i_bus.q2[svpwm_pkg::QW-2:0], g2};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;
endmodule

/* rtl/core/space_vector_pwm_timing_unit.sv */
// Pipeline: 3 + 30 + 1 = 34 register stages.
// Throughput: one vector per cycle through a chain of 30 divider cells, one
// quotient bit per cell; the whole pipeline stalls only while the output holds
// an untaken result.
// Reset (synchronous, active low) clears all valid bits and sets the period to 1000.
module space_vector_pwm_timing_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // alpha_in[12:0], beta_in[25:13]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // sector, t1, t2, cmp1, cmp2, cmp3
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);
    localparam int unsigned NCell = svpwm_pkg::RemW;
    localparam int unsigned NStg  = NCell + 3;

    logic [11:0] r_per;
    logic [NStg-1:0] r_vld;
    logic r_ovld;
    logic en;

    // Pipeline advances unless the output holds an untaken result.
    assign en = !r_ovld || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per <= svpwm_pkg::PeriodReset;
        end else if (cfg_valid) begin
            r_per <= cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[NStg-2:0], s_axis_tvalid};
            r_ovld <= r_vld[NStg-1];
        end
    end

    // Front end, product stage and divider chain.
    svpwm_pkg::t_div_bus fb, pb;
    svpwm_pkg::t_div_bus cb [NCell+1];
    svpwm_front u_front (.i_clk(i_clk), .i_en(en),
        .i_alpha(s_axis_tdata[12:0]), .i_beta(s_axis_tdata[25:13]),
        .i_per(r_per), .o_bus(fb));
    svpwm_prod u_prod (.i_clk(i_clk), .i_en(en), .i_bus(fb), .o_bus(pb));
    assign cb[0] = pb;
    for (genvar g = 0; g < NCell; g++) begin : g_cell
        svpwm_div_cell u_cell (.i_clk(i_clk), .i_en(en), .i_bus(cb[g]),
            .o_bus(cb[g+1]));
    end

    // Final timing and sector permutation.
    svpwm_pkg::t_div_bus lb;
    logic signed [17:0] t1, t2, ta, tb, tc, c1, c2, c3, q1s, q2s;
    always_comb begin
        lb  = cb[NCell];
        q1s = 18'(lb.q1);
        q2s = 18'(lb.q2);
        t1 = lb.ovm ? (lb.neg1 ? -q1s : q1s) : lb.t1;
        t2 = lb.ovm ? (lb.neg2 ? -q2s : q2s) : lb.t2;
        ta = ($signed({6'd0, lb.per}) - t1 - t2) / 18'sd4;
        tb = ta + t1 / 18'sd2;
        tc = tb + t2 / 18'sd2;
        case (lb.code)
            svpwm_pkg::SEC_ONE:   begin c1 = tb; c2 = ta; c3 = tc; end
            svpwm_pkg::SEC_TWO:   begin c1 = ta; c2 = tc; c3 = tb; end
            svpwm_pkg::SEC_THREE: begin c1 = ta; c2 = tb; c3 = tc; end
            svpwm_pkg::SEC_FOUR:  begin c1 = tc; c2 = tb; c3 = ta; end
            svpwm_pkg::SEC_FIVE:  begin c1 = tc; c2 = ta; c3 = tb; end
            default:              begin c1 = tb; c2 = tc; c3 = ta; end
        endcase
    end

    logic [79:0] r_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= {2'd0, c3[14:0], c2[14:0], c1[14:0], t2[14:0], t1[14:0],
                      lb.code};
        end
    end
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_out;

    // A held result must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // Input is refused only when the output is stalled.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused without stall");
endmodule

/* tb/sv/tb_space_vector_pwm_timing_unit.sv */
`timescale 1ns / 1ps

module tb_space_vector_pwm_timing_unit;

    typedef enum logic [1:0] {REQ_VECTOR, REQ_PERIOD, REQ_DRAIN} t_req_kind;

    typedef struct {
        t_req_kind         kind;
        logic signed [12:0] alpha;
        logic signed [12:0] beta;
        logic [11:0]        period;
        logic               calm;
    } t_request;

    // Fields from the highest bits down, so the sector code lands in bits 2:0.
    typedef struct packed {
        logic signed [14:0] cmp3;
        logic signed [14:0] cmp2;
        logic signed [14:0] cmp1;
        logic signed [14:0] t2;
        logic signed [14:0] t1;
        svpwm_pkg::t_sector code;
    } t_timing;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // alpha_in[12:0], beta_in[25:13]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // sector, t1, t2, cmp1, cmp2, cmp3
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;

    t_request pending_requests[$];
    t_timing  expected_timings[$];
    logic [11:0] model_period;
    int  errors;
    int  vectors_sent;
    int  timings_seen;
    int  settle_cycles;
    int  send_gap;
    int  recv_gap;
    logic stimulus_done;
    logic calm_phase;

    space_vector_pwm_timing_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Space-vector timing for one voltage command at the given period.
    function automatic t_timing svpwm_timing(int al, int be, int p);
        int u2, u3, x, y, z, t1, t2, sum, n1, n2, ta, tb, tc;
        t_timing r;
        u2 = (173 * al) / 200 - be / 2;
        u3 = (-173 * al) / 200 - be / 2;
        r.code = svpwm_pkg::t_sector'({u3 > 0, u2 > 0, be > 0});
        x = (173 * be) / 100;
        y = (3 * al) / 2 + (173 * be) / 200;
        z = (-3 * al) / 2 + (173 * be) / 200;
        case (r.code)
            svpwm_pkg::SEC_ONE:   begin t1 = z;  t2 = y;  end
            svpwm_pkg::SEC_TWO:   begin t1 = y;  t2 = -x; end
            svpwm_pkg::SEC_THREE: begin t1 = -z; t2 = x;  end
            svpwm_pkg::SEC_FOUR:  begin t1 = -x; t2 = z;  end
            svpwm_pkg::SEC_FIVE:  begin t1 = x;  t2 = -y; end
            default:              begin t1 = -y; t2 = -z; end
        endcase
        // Overmodulation: scale both times back onto the period.
        sum = t1 + t2;
        if (sum > p) begin
            n1 = (t1 * p) / sum;
            n2 = (t2 * p) / sum;
            t1 = n1;
            t2 = n2;
        end
        ta = (p - t1 - t2) / 4;
        tb = ta + t1 / 2;
        tc = tb + t2 / 2;
        r.t1 = t1[14:0];
        r.t2 = t2[14:0];
        case (r.code)
            svpwm_pkg::SEC_ONE: begin
                r.cmp1 = tb[14:0]; r.cmp2 = ta[14:0]; r.cmp3 = tc[14:0];
            end
            svpwm_pkg::SEC_TWO: begin
                r.cmp1 = ta[14:0]; r.cmp2 = tc[14:0]; r.cmp3 = tb[14:0];
            end
            svpwm_pkg::SEC_THREE: begin
                r.cmp1 = ta[14:0]; r.cmp2 = tb[14:0]; r.cmp3 = tc[14:0];
            end
            svpwm_pkg::SEC_FOUR: begin
                r.cmp1 = tc[14:0]; r.cmp2 = tb[14:0]; r.cmp3 = ta[14:0];
            end
            svpwm_pkg::SEC_FIVE: begin
                r.cmp1 = tc[14:0]; r.cmp2 = ta[14:0]; r.cmp3 = tb[14:0];
            end
            default: begin
                r.cmp1 = tb[14:0]; r.cmp2 = tc[14:0]; r.cmp3 = ta[14:0];
            end
        endcase
        return r;
    endfunction

    task automatic queue_vector(int al, int be, logic calm);
        t_request r;
        r.kind = REQ_VECTOR;
        r.alpha = al[12:0];
        r.beta = be[12:0];
        r.period = '0;
        r.calm = calm;
        pending_requests.push_back(r);
    endtask

    task automatic queue_control(t_req_kind kind, logic [11:0] period);
        t_request r;
        r.kind = kind;
        r.alpha = '0;
        r.beta = '0;
        r.period = period;
        r.calm = 1'b0;
        pending_requests.push_back(r);
    endtask

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stimulus plan: directed vectors, then random phases at several periods.
    initial begin
        int periods[8];
        int dir_a[20];
        int dir_b[20];
        int mag;
        int a;
        int b;
        int sel;
        dir_a = '{0, -4096, 4095, -4096, 4095, 0, 0, 4095, -4096, 1000,
                  0, -1000, -1000, 0, 1000, 1, -1, 1, 0, 4095};
        dir_b = '{0, -4096, 4095, 4095, -4096, 4095, -4096, 0, 0, 300,
                  1000, 300, -300, -1000, -300, 1, -1, 0, 1, 4095};
        periods = '{1000, 100, 4095, 0, 4000, 0, 0, 0};
        for (int k = 5; k < 8; k++) periods[k] = $urandom_range(100, 4000);
        for (int k = 0; k < 20; k++) queue_vector(dir_a[k], dir_b[k], 1'b0);
        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) queue_control(REQ_PERIOD, 12'(periods[ph]));
            if (ph == 0) queue_control(REQ_PERIOD, 12'd1000);
            mag = (periods[ph] < 64) ? 64 : periods[ph];
            for (int k = 0; k < 228; k++) begin
                sel = $urandom_range(0, 9);
                if (sel < 2) begin
                    a = $urandom_range(0, 8191) - 4096;
                    b = $urandom_range(0, 8191) - 4096;
                end else if (sel < 7) begin
                    a = $urandom_range(0, 2 * mag) - mag;
                    b = $urandom_range(0, 2 * mag) - mag;
                    if (a > 4095) a = 4095;
                    if (b > 4095) b = 4095;
                end else begin
                    a = $urandom_range(0, 128) - 64;
                    b = $urandom_range(0, 128) - 64;
                end
                queue_vector(a, b, (ph == 7) && (k >= 78));
                if (ph == 3 && k == 100) queue_control(REQ_DRAIN, '0);
            end
        end
    end

    // Reset sequence.
    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver for vectors and period writes.
    always @(posedge i_clk) begin
        logic vfree;
        logic cfree;
        logic idle;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            cfg_valid <= 1'b0;
            cfg_data <= '0;
            vectors_sent <= 0;
            settle_cycles <= 0;
            send_gap <= 0;
            stimulus_done <= 1'b0;
            calm_phase <= 1'b0;
        end else begin
            vfree = !s_axis_tvalid || s_axis_tready;
            cfree = !cfg_valid || cfg_ready;
            idle = vfree && cfree && (vectors_sent + (s_axis_tvalid && s_axis_tready))
                   == (timings_seen + (m_axis_tvalid && m_axis_tready));
            if (s_axis_tvalid && s_axis_tready) vectors_sent <= vectors_sent + 1;
            settle_cycles <= idle ? settle_cycles + 1 : 0;
            if (vfree && cfree) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                    cfg_valid <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                    cfg_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end else if (pending_requests[0].kind == REQ_VECTOR) begin
                    s_axis_tdata <= {6'd0, pending_requests[0].beta,
                                     pending_requests[0].alpha};
                    s_axis_tvalid <= 1'b1;
                    cfg_valid <= 1'b0;
                    calm_phase <= pending_requests[0].calm;
                    if (!pending_requests[0].calm && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 6);
                    void'(pending_requests.pop_front());
                end else if (pending_requests[0].kind == REQ_PERIOD) begin
                    // Period writes wait until the pipeline has fully drained.
                    s_axis_tvalid <= 1'b0;
                    if (idle && settle_cycles >= 40) begin
                        cfg_data <= pending_requests[0].period;
                        cfg_valid <= 1'b1;
                        void'(pending_requests.pop_front());
                    end else begin
                        cfg_valid <= 1'b0;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                    cfg_valid <= 1'b0;
                    if (idle) void'(pending_requests.pop_front());
                end
            end
        end
    end

    // Receiver backpressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end else if (calm_phase) begin
            m_axis_tready <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            recv_gap <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: checks results and predicts each accepted vector.
    always @(posedge i_clk) begin
        t_timing got;
        t_timing want;
        int nerr;
        nerr = 0;
        if (!i_rst_n) begin
            model_period <= 12'd1000;
            timings_seen <= 0;
            errors <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                timings_seen <= timings_seen + 1;
                got = m_axis_tdata[77:0];
                if (expected_timings.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    nerr++;
                end else begin
                    want = expected_timings.pop_front();
                    if (got.code !== want.code) begin
                        $error("sector_code exp %0d got %0d", want.code, got.code);
                        nerr++;
                    end
                    if (got.t1 !== want.t1) begin
                        $error("active_time_first exp %0d got %0d", want.t1, got.t1);
                        nerr++;
                    end
                    if (got.t2 !== want.t2) begin
                        $error("active_time_second exp %0d got %0d", want.t2, got.t2);
                        nerr++;
                    end
                    if (got.cmp1 !== want.cmp1) begin
                        $error("compare_phase_one exp %0d got %0d", want.cmp1, got.cmp1);
                        nerr++;
                    end
                    if (got.cmp2 !== want.cmp2) begin
                        $error("compare_phase_two exp %0d got %0d", want.cmp2, got.cmp2);
                        nerr++;
                    end
                    if (got.cmp3 !== want.cmp3) begin
                        $error("compare_phase_three exp %0d got %0d",
                               want.cmp3, got.cmp3);
                        nerr++;
                    end
                end
            end
            if (nerr != 0) errors <= errors + nerr;
            if (s_axis_tvalid && s_axis_tready)
                expected_timings.push_back(svpwm_timing(
                    int'($signed(s_axis_tdata[12:0])),
                    int'($signed(s_axis_tdata[25:13])), int'(model_period)));
            if (cfg_valid && cfg_ready) model_period <= cfg_data;
        end
    end

    // End of run.
    initial begin
        @(posedge i_rst_n);
        while (!stimulus_done || expected_timings.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && expected_timings.size() == 0) begin
            $display("space_vector_pwm_timing_unit test passed");
        end else begin
            $display("space_vector_pwm_timing_unit test failed");
        end
        $finish;
    end

    // Timeout.
    initial begin
        #20ms;
        $display("space_vector_pwm_timing_unit test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_front.sv
rtl/core/svpwm_prod.sv
rtl/core/svpwm_div_cell.sv
rtl/core/space_vector_pwm_timing_unit.sv
tb/sv/tb_space_vector_pwm_timing_unit.sv
